### src/rds_pkg.sv
// Shared types and constants for the ranging door sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rds_pkg;

  // Opcodes of an input word
  localparam logic [2:0] OP_SAMPLE  = 3'd0;
  localparam logic [2:0] OP_DETECT  = 3'd1;
  localparam logic [2:0] OP_SPEED   = 3'd2;
  localparam logic [2:0] OP_PICTURE = 3'd3;
  localparam logic [2:0] OP_OPEN    = 3'd4;
  localparam logic [2:0] OP_CLOSE   = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LO    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HI    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BESTSHOT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_DIST   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WAIT   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ULTRA_THR   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_THR  = 4'd7;

  // Sequencer modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_DETECT = 3'd1,
    MODE_SPEED  = 3'd2,
    MODE_OPEN   = 3'd3,
    MODE_CLOSE  = 3'd4
  } mode_t;

  // Algorithm constants
  localparam logic [15:0] IRREGULAR_LIMIT = 16'd4000;
  localparam logic [2:0]  PRESENCE_LAST   = 3'd5;   // sixth hit in a row
  localparam logic [2:0]  WINDOW_LAST     = 3'd4;   // fifth sample of a window
  localparam logic [2:0]  MAX_BACKWARD    = 3'd5;
  localparam logic [1:0]  STEP_TARGET     = 2'd3;
  // x/5 == (x * 419431) >> 21 for every x below 699050
  localparam logic [18:0] DIV5_RECIP      = 19'd419431;
  localparam int unsigned DIV5_SHIFT      = 21;

  // Configuration register set
  typedef struct packed {
    logic [15:0] range_lo;
    logic [15:0] range_hi;
    logic [15:0] bestshot_limit;
    logic [15:0] gate_floor;
    logic [7:0]  open_wait_ticks;
    logic [15:0] ultra_threshold;
    logic [15:0] high_threshold;
    logic [15:0] normal_threshold;
  } cfg_t;

  // Input word
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] distance;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic        detected;
    logic        speed_done;
    logic [1:0]  speed_level;
    logic [19:0] open_distance;
    logic        drive_open;
    logic        open_done;
    logic        drive_close;
    logic        picture_now;
  } out_item_t;

endpackage

`default_nettype wire

### src/rds_cfg_regs.sv
// Configuration register file of the ranging door sequencer.
// Depends on rds_pkg for the register set type and index codes.
`default_nettype none

module rds_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [rds_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [15:0]                   wr_data,
  output rds_pkg::cfg_t                      cfg
);
  import rds_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_RANGE_LO:   cfg_nxt.range_lo         = wr_data;
        CFG_RANGE_HI:   cfg_nxt.range_hi         = wr_data;
        CFG_BESTSHOT:   cfg_nxt.bestshot_limit   = wr_data;
        CFG_GATE_DIST:  cfg_nxt.gate_floor       = wr_data;
        CFG_OPEN_WAIT:  cfg_nxt.open_wait_ticks  = wr_data[7:0];
        CFG_ULTRA_THR:  cfg_nxt.ultra_threshold  = wr_data;
        CFG_HIGH_THR:   cfg_nxt.high_threshold   = wr_data;
        CFG_NORMAL_THR: cfg_nxt.normal_threshold = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_lo         <= 16'd50;
      cfg_r.range_hi         <= 16'd700;
      cfg_r.bestshot_limit   <= 16'd220;
      cfg_r.gate_floor       <= 16'd250;
      cfg_r.open_wait_ticks  <= 8'd200;
      cfg_r.ultra_threshold  <= 16'd500;
      cfg_r.high_threshold   <= 16'd300;
      cfg_r.normal_threshold <= 16'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### src/rds_core.sv
// Sequencer state and the single-pass update for one word.
// Depends on rds_pkg for word types, modes and constants.
`default_nettype none

module rds_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              upd,
  input  wire rds_pkg::in_item_t item,
  input  wire rds_pkg::cfg_t     cfg,
  output rds_pkg::out_item_t     result
);
  import rds_pkg::*;

  // State registers
  mode_t       mode_r,    mode_nxt;
  logic [2:0]  pres_r,    pres_nxt;
  logic [2:0]  wcnt_r,    wcnt_nxt;
  logic [18:0] wsum_r,    wsum_nxt;
  logic [1:0]  step_r,    step_nxt;
  logic [2:0]  back_r,    back_nxt;
  logic [15:0] prev_r,    prev_nxt;
  logic [16:0] fsum_r,    fsum_nxt;
  logic [15:0] mstep_r,   mstep_nxt;
  logic [19:0] od_r,      od_nxt;
  logic [7:0]  wait_r,    wait_nxt;
  logic        armed_r,   armed_nxt;
  logic        taken_r,   taken_nxt;

  // Per-word event flags
  logic det_f, spd_f, mopen_f, odone_f, mclose_f, pic_f;

  // Window mean: running sum plus this sample, divided by five
  logic [18:0] wsum_sum;
  logic [37:0] mean_prod;
  logic [15:0] mean;

  assign wsum_sum  = wsum_r + {3'b000, item.distance};
  assign mean_prod = 38'(wsum_sum) * 38'(DIV5_RECIP);
  assign mean      = mean_prod[DIV5_SHIFT+15:DIV5_SHIFT];

  // Forward sum and step count after the window update, before completion
  logic [16:0] fsum_nxt_pre;
  logic [1:0]  step_nxt_pre;

  // Opening distance from a new mean step: ten times, at least the gate
  logic [15:0] new_mstep;
  logic [19:0] new_od_raw;
  logic [19:0] new_od;

  function automatic logic [1:0] level_of(input logic [15:0] m, input cfg_t c);
    logic [1:0] lvl;
    if (m > c.ultra_threshold)       lvl = 2'd3;
    else if (m > c.high_threshold)   lvl = 2'd2;
    else if (m > c.normal_threshold) lvl = 2'd1;
    else                             lvl = 2'd0;
    return lvl;
  endfunction

  // Next state
  always_comb begin
    logic       is_sample;
    logic       in_range;
    logic       bwd_hit;
    logic [7:0] delay;
    logic [7:0] wait_v;

    mode_nxt     = mode_r;
    pres_nxt     = pres_r;
    wcnt_nxt     = wcnt_r;
    wsum_nxt     = wsum_r;
    step_nxt_pre = step_r;
    back_nxt     = back_r;
    prev_nxt     = prev_r;
    fsum_nxt_pre = fsum_r;
    mstep_nxt    = mstep_r;
    od_nxt       = od_r;
    wait_nxt     = wait_r;
    armed_nxt    = armed_r;
    taken_nxt    = taken_r;
    det_f        = 1'b0;
    spd_f        = 1'b0;
    mopen_f      = 1'b0;
    odone_f      = 1'b0;
    mclose_f     = 1'b0;
    pic_f        = 1'b0;
    bwd_hit      = 1'b0;
    delay        = cfg.open_wait_ticks;
    wait_v       = wait_r;

    is_sample = (item.opcode == OP_SAMPLE);
    in_range  = (item.distance > cfg.range_lo) && (item.distance < cfg.range_hi);

    // command decode
    case (item.opcode)
      OP_DETECT:  mode_nxt = MODE_DETECT;
      OP_SPEED:   mode_nxt = MODE_SPEED;
      OP_PICTURE: if (!taken_r) armed_nxt = 1'b1;
      OP_OPEN:    mode_nxt = MODE_OPEN;
      OP_CLOSE:   mode_nxt = MODE_CLOSE;
      default: ;
    endcase

    if (is_sample) begin
      // presence detect
      if (mode_r == MODE_DETECT && in_range) begin
        if (pres_r >= PRESENCE_LAST) begin
          det_f    = 1'b1;
          mode_nxt = MODE_IDLE;
          pres_nxt = 3'd0;
        end else begin
          pres_nxt = pres_r + 3'd1;
        end
      end else begin
        pres_nxt = 3'd0;
      end

      // speed windows
      if (mode_r == MODE_SPEED) begin
        if (wcnt_r >= WINDOW_LAST) begin
          wsum_nxt = '0;
          wcnt_nxt = 3'd0;
          if (mean > IRREGULAR_LIMIT) begin
            bwd_hit = 1'b1;
          end else if (step_r == 2'd0) begin
            prev_nxt     = mean;
            step_nxt_pre = 2'd1;
          end else if (prev_r > mean) begin
            fsum_nxt_pre = fsum_r + {1'b0, prev_r - mean};
            prev_nxt     = mean;
            back_nxt     = 3'd0;
            step_nxt_pre = step_r + 2'd1;
          end else begin
            bwd_hit = 1'b1;
          end
        end else begin
          wsum_nxt = wsum_sum;
          wcnt_nxt = wcnt_r + 3'd1;
        end
        // too many backward windows restart the estimate
        if (bwd_hit) begin
          if (back_r >= MAX_BACKWARD) begin
            step_nxt_pre = 2'd0;
            back_nxt     = 3'd0;
            fsum_nxt_pre = '0;
          end else begin
            back_nxt = back_r + 3'd1;
          end
        end
      end

      // door opening
      if (mode_r == MODE_OPEN) begin
        if (wait_r == 8'd0 && {4'h0, item.distance} < od_r) begin
          mopen_f = 1'b1;
          wait_v  = 8'd1;
        end
        if (mstep_r > cfg.ultra_threshold)     delay = {2'b00, cfg.open_wait_ticks[7:2]};
        else if (mstep_r > cfg.high_threshold) delay = {1'b0, cfg.open_wait_ticks[7:1]};
        else                                   delay = cfg.open_wait_ticks;
        if (wait_v != 8'd0) begin
          wait_v = wait_v + 8'd1;
          if (wait_v >= delay) begin
            odone_f  = 1'b1;
            mode_nxt = MODE_IDLE;
            wait_v   = 8'd0;
          end
        end
        wait_nxt = wait_v;
      end

      // door closing
      if (mode_r == MODE_CLOSE &&
          (item.distance < cfg.range_lo || item.distance > cfg.range_hi)) begin
        mclose_f  = 1'b1;
        mode_nxt  = MODE_IDLE;
        taken_nxt = 1'b0;
        armed_nxt = 1'b0;
      end

      // picture trigger
      if (armed_nxt && item.distance < cfg.bestshot_limit) begin
        pic_f     = 1'b1;
        armed_nxt = 1'b0;
        taken_nxt = 1'b1;
      end
    end

    // estimate complete
    step_nxt   = step_nxt_pre;
    fsum_nxt   = fsum_nxt_pre;
    new_mstep  = fsum_nxt_pre[16:1];
    new_od_raw = {1'b0, new_mstep, 3'b000} + {3'b000, new_mstep, 1'b0};
    new_od     = (new_od_raw < {4'h0, cfg.gate_floor}) ?
                 {4'h0, cfg.gate_floor} : new_od_raw;
    if (is_sample && mode_r == MODE_SPEED && step_nxt_pre >= STEP_TARGET) begin
      mstep_nxt = new_mstep;
      od_nxt    = new_od;
      spd_f     = 1'b1;
      mode_nxt  = MODE_IDLE;
      step_nxt  = 2'd0;
      fsum_nxt  = '0;
    end
  end

  // Result word
  always_comb begin
    result.detected      = det_f;
    result.speed_done    = spd_f;
    result.speed_level   = level_of(mstep_nxt, cfg);
    result.open_distance = od_nxt;
    result.drive_open    = mopen_f;
    result.open_done     = odone_f;
    result.drive_close   = mclose_f;
    result.picture_now   = pic_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pres_r  <= '0;
      wcnt_r  <= '0;
      wsum_r  <= '0;
      step_r  <= '0;
      back_r  <= '0;
      prev_r  <= '0;
      fsum_r  <= '0;
      mstep_r <= '0;
      od_r    <= '0;
      wait_r  <= '0;
      armed_r <= 1'b0;
      taken_r <= 1'b0;
    end else if (upd) begin
      mode_r  <= mode_nxt;
      pres_r  <= pres_nxt;
      wcnt_r  <= wcnt_nxt;
      wsum_r  <= wsum_nxt;
      step_r  <= step_nxt;
      back_r  <= back_nxt;
      prev_r  <= prev_nxt;
      fsum_r  <= fsum_nxt;
      mstep_r <= mstep_nxt;
      od_r    <= od_nxt;
      wait_r  <= wait_nxt;
      armed_r <= armed_nxt;
      taken_r <= taken_nxt;
    end
  end

  // Counter bounds and completion behavior
  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= WINDOW_LAST) else $error("window count out of range");
  a_back_bound: assert property (@(posedge clk) disable iff (!rst_n)
    back_r <= MAX_BACKWARD) else $error("backward count out of range");
  a_pres_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pres_r <= PRESENCE_LAST) else $error("presence count out of range");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < STEP_TARGET) else $error("step count reached target and stayed");
  a_speed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && spd_f) |=> (mode_r == MODE_IDLE && fsum_r == '0))
    else $error("speed estimate did not return to idle");

endmodule

`default_nettype wire

### src/ranging_door_sequencer_unit.sv
// Pipeline: a word accepted into the input register passes to the result
// register once that register is free or being drained.
// Throughput: one word per cycle while results drain; a new word is taken
// while a result waits as long as the input register is free.
// Reset: synchronous, active low; mode, counters and handshakes clear and
// the configuration registers load their defaults.
`default_nettype none

module ranging_door_sequencer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rds_pkg::in_item_t             in_data,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rds_pkg::out_item_t                 out_data,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import rds_pkg::*;

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t result;
  logic      adv;
  logic      upd;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  rds_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage advance: output register free or being drained
  assign adv      = !out_valid_r || out_ready;
  assign upd      = in_valid_r && adv;
  assign in_ready = !in_valid_r || adv;

  rds_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (upd),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // Handshake next state
  always_comb begin
    in_valid_nxt  = in_ready ? in_valid : in_valid_r;
    out_valid_nxt = adv ? in_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (upd) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### sim/ranging_door_sequencer_unit_test.sv
// Self-checking testbench for ranging_door_sequencer_unit: directed words, then
// random approach sequences under several register settings, checked per field.
// Depends on rds_pkg and the ranging_door_sequencer_unit RTL.
module ranging_door_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rds_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned RESULT_LATENCY = 10;
  // opcodes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef enum int unsigned {
    SET_FLOOR,
    SET_CEILING,
    SET_SHORT_WAIT,
    SET_TYPICAL
  } setting_kind_t;

  // DUT ports
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  // bookkeeping
  out_item_t   door_results_due[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned hold_left   = 0;
  bit          gaps_on     = 1'b1;

  // register copy, reset values
  cfg_t reg_model = '{range_lo: 16'd50, range_hi: 16'd700, bestshot_limit: 16'd220,
                      gate_floor: 16'd250, open_wait_ticks: 8'd200,
                      ultra_threshold: 16'd500, high_threshold: 16'd300,
                      normal_threshold: 16'd50};

  // sequencer state copy
  mode_t       seq_mode     = MODE_IDLE;
  logic [2:0]  presence_cnt = '0;
  logic [2:0]  window_cnt   = '0;
  logic [18:0] window_acc   = '0;
  logic [2:0]  step_cnt     = '0;
  logic [2:0]  backward_cnt = '0;
  logic [15:0] prev_mean    = '0;
  logic [16:0] forward_acc  = '0;
  logic [15:0] mean_step_r  = '0;
  logic [19:0] open_dist    = '0;
  logic [7:0]  wait_cnt     = '0;
  logic        pic_armed    = 1'b0;
  logic        pic_taken    = 1'b0;

  ranging_door_sequencer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned rand_between(int unsigned lo, int unsigned hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi, lo);
  endfunction

  function automatic in_item_t make_word(logic [2:0] op, logic [15:0] dist_mm);
    in_item_t w;
    w.opcode   = op;
    w.distance = dist_mm;
    return w;
  endfunction

  // Advance the sequencer copy by one word and return the result it gives
  function automatic out_item_t advance_sequencer(in_item_t w);
    out_item_t   r;
    logic [15:0] d;
    logic [15:0] mean;
    logic [7:0]  delay;
    r = '0;
    d = w.distance;

    // commands
    case (w.opcode)
      OP_DETECT:  seq_mode = MODE_DETECT;
      OP_SPEED:   seq_mode = MODE_SPEED;
      OP_PICTURE: if (!pic_taken) pic_armed = 1'b1;
      OP_OPEN:    seq_mode = MODE_OPEN;
      OP_CLOSE:   seq_mode = MODE_CLOSE;
      default: ;
    endcase

    if (w.opcode == OP_SAMPLE) begin
      // presence: six in-range samples in a row
      if (seq_mode == MODE_DETECT && d > reg_model.range_lo && d < reg_model.range_hi) begin
        presence_cnt = presence_cnt + 3'd1;
        if (presence_cnt > PRESENCE_LAST) begin
          r.detected   = 1'b1;
          seq_mode     = MODE_IDLE;
          presence_cnt = '0;
        end
      end else begin
        presence_cnt = '0;
      end

      // speed: window means, forward steps between them
      if (seq_mode == MODE_SPEED) begin
        window_acc = window_acc + 19'(d);
        window_cnt = window_cnt + 3'd1;
        if (window_cnt > WINDOW_LAST) begin
          mean       = 16'(window_acc / 19'd5);
          window_acc = '0;
          window_cnt = '0;
          if (mean <= IRREGULAR_LIMIT && step_cnt == 3'd0) begin
            prev_mean = mean;
            step_cnt  = 3'd1;
          end else if (mean <= IRREGULAR_LIMIT && prev_mean > mean) begin
            forward_acc  = forward_acc + 17'(prev_mean - mean);
            prev_mean    = mean;
            backward_cnt = '0;
            step_cnt     = step_cnt + 3'd1;
          end else begin
            // receding or irregular window; too many restart the estimate
            backward_cnt = backward_cnt + 3'd1;
            if (backward_cnt > MAX_BACKWARD) begin
              step_cnt     = '0;
              backward_cnt = '0;
              forward_acc  = '0;
            end
          end
        end
        if (step_cnt >= 3'(STEP_TARGET)) begin
          mean_step_r = 16'(forward_acc / 17'd2);
          open_dist   = 20'(mean_step_r) * 20'd10;
          if (open_dist < 20'(reg_model.gate_floor)) open_dist = 20'(reg_model.gate_floor);
          r.speed_done = 1'b1;
          seq_mode     = MODE_IDLE;
          step_cnt     = '0;
          forward_acc  = '0;
        end
      end

      // open: start motor, then wait a speed-dependent number of samples
      if (seq_mode == MODE_OPEN) begin
        if (20'(d) < open_dist && wait_cnt == 8'd0) begin
          r.drive_open = 1'b1;
          wait_cnt     = 8'd1;
        end
        if (wait_cnt != 8'd0) begin
          wait_cnt = wait_cnt + 8'd1;
          if (mean_step_r > reg_model.ultra_threshold) delay = reg_model.open_wait_ticks >> 2;
          else if (mean_step_r > reg_model.high_threshold) delay = reg_model.open_wait_ticks >> 1;
          else delay = reg_model.open_wait_ticks;
          if (wait_cnt >= delay) begin
            r.open_done = 1'b1;
            seq_mode    = MODE_IDLE;
            wait_cnt    = '0;
          end
        end
      end

      // close once the object has left the range
      if (seq_mode == MODE_CLOSE && (d < reg_model.range_lo || d > reg_model.range_hi)) begin
        r.drive_close = 1'b1;
        seq_mode      = MODE_IDLE;
        pic_taken     = 1'b0;
        pic_armed     = 1'b0;
      end

      // picture trigger
      if (pic_armed && d < reg_model.bestshot_limit) begin
        r.picture_now = 1'b1;
        pic_armed     = 1'b0;
        pic_taken     = 1'b1;
      end
    end

    if (mean_step_r > reg_model.ultra_threshold) r.speed_level = 2'd3;
    else if (mean_step_r > reg_model.high_threshold) r.speed_level = 2'd2;
    else if (mean_step_r > reg_model.normal_threshold) r.speed_level = 2'd1;
    else r.speed_level = 2'd0;
    r.open_distance = open_dist;
    return r;
  endfunction

  function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result side: check each word, stall ready at random
  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (door_results_due.size() == 0) begin
          $display("%0t ns: result word %h with none expected", $time, out_data);
          error_count++;
        end else begin
          due = door_results_due.pop_front();
          check_field("detected", 20'(due.detected), 20'(out_data.detected));
          check_field("speed_done", 20'(due.speed_done), 20'(out_data.speed_done));
          check_field("speed_level", 20'(due.speed_level), 20'(out_data.speed_level));
          check_field("open_distance", due.open_distance, out_data.open_distance);
          check_field("drive_open", 20'(due.drive_open), 20'(out_data.drive_open));
          check_field("open_done", 20'(due.open_done), 20'(out_data.open_done));
          check_field("drive_close", 20'(due.drive_close), 20'(out_data.drive_close));
          check_field("picture_now", 20'(due.picture_now), 20'(out_data.picture_now));
        end
        hold_left = gaps_on ? $urandom_range(0, 19) : 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_ready <= (hold_left == 0);
    end
  end

  // Send one word; valid stays high afterwards unless the next word idles first
  task automatic send_word(input in_item_t w);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    door_results_due.push_back(advance_sequencer(w));
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (door_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RANGE_LO:   reg_model.range_lo         = value;
      CFG_RANGE_HI:   reg_model.range_hi         = value;
      CFG_BESTSHOT:   reg_model.bestshot_limit   = value;
      CFG_GATE_DIST:  reg_model.gate_floor       = value;
      CFG_OPEN_WAIT:  reg_model.open_wait_ticks  = value[7:0];
      CFG_ULTRA_THR:  reg_model.ultra_threshold  = value;
      CFG_HIGH_THR:   reg_model.high_threshold   = value;
      CFG_NORMAL_THR: reg_model.normal_threshold = value;
      default: ;
    endcase
  endtask

  // Write the whole register set while the block is idle
  task automatic load_settings(input cfg_t c);
    drain_results();
    write_reg(CFG_RANGE_LO, c.range_lo);
    write_reg(CFG_RANGE_HI, c.range_hi);
    write_reg(CFG_BESTSHOT, c.bestshot_limit);
    write_reg(CFG_GATE_DIST, c.gate_floor);
    // upper byte is don't-care for the 8-bit wait register
    write_reg(CFG_OPEN_WAIT, {8'($urandom), c.open_wait_ticks});
    write_reg(CFG_ULTRA_THR, c.ultra_threshold);
    write_reg(CFG_HIGH_THR, c.high_threshold);
    write_reg(CFG_NORMAL_THR, c.normal_threshold);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t pick_settings(setting_kind_t kind);
    cfg_t c;
    case (kind)
      SET_FLOOR: begin
        c = '0;
        c.open_wait_ticks = 8'd4;
      end
      SET_CEILING: c = '1;
      default: begin
        c.range_lo         = 16'(rand_between(0, 300));
        c.range_hi         = 16'(c.range_lo + rand_between(100, 3000));
        c.bestshot_limit   = 16'(rand_between(0, 1500));
        c.gate_floor       = 16'(rand_between(0, 2000));
        c.open_wait_ticks  = (kind == SET_SHORT_WAIT) ? 8'(rand_between(4, 7))
                                                     : 8'(rand_between(8, 60));
        c.normal_threshold = 16'(rand_between(0, 100));
        c.high_threshold   = 16'(c.normal_threshold + rand_between(0, 300));
        c.ultra_threshold  = 16'(c.high_threshold + rand_between(0, 400));
      end
    endcase
    return c;
  endfunction

  // Random sequences: an approaching object seen in each mode
  task automatic seq_detect();
    int unsigned d;
    send_word(make_word(OP_DETECT, 16'($urandom)));
    repeat (rand_between(3, 8)) begin
      if (reg_model.range_hi > reg_model.range_lo + 1 && $urandom_range(0, 7) != 0)
        d = rand_between(reg_model.range_lo + 1, reg_model.range_hi - 1);
      else
        d = $urandom_range(0, 65535);
      send_word(make_word(OP_SAMPLE, 16'(d)));
    end
  endtask

  task automatic seq_speed();
    int unsigned pace, count, start, k;
    int          level;
    send_word(make_word(OP_SPEED, 16'($urandom)));
    pace  = rand_between(0, 150);
    count = rand_between(12, 30);
    // starts up to a little past the irregular limit
    start = rand_between(pace * count, 4300);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) level = $urandom_range(0, 65535);
      else level = int'(start) - int'(k * pace) + int'($urandom_range(0, 20)) - 10;
      if (level < 0) level = 0;
      send_word(make_word(OP_SAMPLE, 16'(level)));
    end
  endtask

  task automatic seq_open();
    int unsigned limit;
    send_word(make_word(OP_OPEN, 16'($urandom)));
    limit = (open_dist > 20'd65535) ? 65535 : int'(open_dist);
    // still beyond the opening distance
    repeat ($urandom_range(0, 3)) send_word(make_word(OP_SAMPLE, 16'(rand_between(limit, 65535))));
    repeat (rand_between(1, reg_model.open_wait_ticks + 3)) begin
      if (limit == 0) send_word(make_word(OP_SAMPLE, 16'($urandom)));
      else send_word(make_word(OP_SAMPLE, 16'(rand_between(0, limit - 1))));
    end
  endtask

  task automatic seq_close();
    int unsigned d;
    send_word(make_word(OP_CLOSE, 16'($urandom)));
    repeat ($urandom_range(0, 3))
      send_word(make_word(OP_SAMPLE, 16'(rand_between(reg_model.range_lo, reg_model.range_hi))));
    if (reg_model.range_lo > 0 && $urandom_range(0, 1) == 1)
      d = rand_between(0, reg_model.range_lo - 1);
    else if (reg_model.range_hi < 16'hFFFF)
      d = rand_between(reg_model.range_hi + 1, 65535);
    else
      d = $urandom_range(0, 65535);
    send_word(make_word(OP_SAMPLE, 16'(d)));
  endtask

  task automatic seq_picture();
    int unsigned span;
    send_word(make_word(OP_PICTURE, 16'($urandom)));
    span = 2 * reg_model.bestshot_limit + 10;
    if (span > 65535) span = 65535;
    repeat (rand_between(1, 4)) send_word(make_word(OP_SAMPLE, 16'(rand_between(0, span))));
  endtask

  task automatic seq_noise();
    repeat (rand_between(1, 4)) send_word(make_word(3'($urandom), 16'($urandom)));
  endtask

  task automatic run_mix(input int unsigned count);
    int unsigned target, pick;
    target  = words_sent + count;
    gaps_on = 1'b1;
    while (words_sent < target) begin
      // stretches without idling on either side
      if ($urandom_range(0, 29) == 0) gaps_on = !gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 25) seq_speed();
      else if (pick < 45) seq_open();
      else if (pick < 60) seq_detect();
      else if (pick < 75) seq_close();
      else if (pick < 85) seq_picture();
      else seq_noise();
    end
    drain_results();
    gaps_on = 1'b1;
  endtask

  // Directed: sample, speed, open, close and spare opcodes, distance extremes
  task automatic test_opcodes();
    send_word(make_word(OP_SAMPLE, 16'h0000));
    send_word(make_word(OP_SAMPLE, 16'hFFFF));
    send_word(make_word(OP_SPARE_A, 16'hFFFF));
    send_word(make_word(OP_SPARE_B, 16'h5555));
    send_word(make_word(OP_SPEED, 16'hAAAA));
    send_word(make_word(OP_SAMPLE, 16'h1234));
    send_word(make_word(OP_OPEN, 16'h0000));
    send_word(make_word(OP_SAMPLE, 16'h0000));
    send_word(make_word(OP_CLOSE, 16'hFFFF));
    send_word(make_word(OP_SAMPLE, 16'h0000));
    drain_results();
  endtask

  // Directed: boundary sample breaks the run, then six in range
  task automatic test_presence();
    send_word(make_word(OP_DETECT, 16'd0));
    send_word(make_word(OP_SAMPLE, 16'd50));
    send_word(make_word(OP_SAMPLE, 16'd51));
    send_word(make_word(OP_SAMPLE, 16'd699));
    send_word(make_word(OP_SAMPLE, 16'd300));
    send_word(make_word(OP_SAMPLE, 16'd400));
    send_word(make_word(OP_SAMPLE, 16'd500));
    send_word(make_word(OP_SAMPLE, 16'd600));
    drain_results();
  endtask

  // Directed: picture fires once, re-arm ignored until a close
  task automatic test_picture_close();
    send_word(make_word(OP_PICTURE, 16'd0));
    send_word(make_word(OP_SAMPLE, 16'hFFFF));
    send_word(make_word(OP_SAMPLE, 16'd0));
    send_word(make_word(OP_PICTURE, 16'd0));
    send_word(make_word(OP_SAMPLE, 16'd0));
    send_word(make_word(OP_CLOSE, 16'd0));
    send_word(make_word(OP_SAMPLE, 16'hFFFF));
    send_word(make_word(OP_PICTURE, 16'd0));
    send_word(make_word(OP_SAMPLE, 16'd219));
    drain_results();
  endtask

  task automatic test_default_mix();
    run_mix(450);
  endtask

  // Floor, ceiling, then a mix of short open wait and typical settings
  task automatic test_setting_sweep();
    setting_kind_t plan[7];
    plan = '{SET_FLOOR, SET_CEILING, SET_SHORT_WAIT, SET_TYPICAL, SET_TYPICAL,
             SET_SHORT_WAIT, SET_TYPICAL};
    foreach (plan[i]) begin
      load_settings(pick_settings(plan[i]));
      run_mix(210);
    end
  endtask

  // Test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_opcodes();
    test_presence();
    test_picture_close();
    test_default_mix();
    test_setting_sweep();
    drain_results();
    repeat (RESULT_LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
